// File: rtl/tpfc_pkg.sv
package tpfc_pkg;

   localparam int RAW_BITS_DEFAULT   = 12;
   localparam int COORD_BITS_DEFAULT = 10;
   localparam int GAIN_BITS          = 17;
   localparam int FRAC_BITS          = 16;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int CSR_DATA_BITS      = 17;

   localparam int CORNER_WIDTH  = 24;
   localparam int CORNER_HEIGHT = 16;

   localparam int CENTER_RESET = 2048;
   localparam int GAIN_X_RESET = 4681;
   localparam int GAIN_Y_RESET = 3744;
   localparam int WIDTH_RESET  = 240;
   localparam int HEIGHT_RESET = 320;
   localparam int AGREE_RESET  = 10;

   typedef enum logic [2:0] {
      OUTCOME_DRAW     = 3'd0,
      OUTCOME_CORNER   = 3'd1,
      OUTCOME_OFF      = 3'd2,
      OUTCOME_DISAGREE = 3'd3,
      OUTCOME_PEN_UP   = 3'd4
   } outcome_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X    = 3'd0,
      CSR_CENTER_Y    = 3'd1,
      CSR_GAIN_X      = 3'd2,
      CSR_GAIN_Y      = 3'd3,
      CSR_WIDTH       = 3'd4,
      CSR_HEIGHT      = 3'd5,
      CSR_AGREE_LIMIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic pen_down;
      logic agree;
   } mid_flags_type;

endpackage

// File: rtl/tpfc_if.sv
interface tpfc_req_if #(
   parameter int RAW_BITS = tpfc_pkg::RAW_BITS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic                pen_down;
   logic [RAW_BITS-1:0] first_x;
   logic [RAW_BITS-1:0] first_y;
   logic [RAW_BITS-1:0] second_x;
   logic [RAW_BITS-1:0] second_y;

   modport source (output valid, pen_down, first_x, first_y, second_x, second_y,
                   input ready);
   modport sink   (input valid, pen_down, first_x, first_y, second_x, second_y,
                   output ready);
endinterface

interface tpfc_rsp_if #(
   parameter int RAW_BITS   = tpfc_pkg::RAW_BITS_DEFAULT,
   parameter int COORD_BITS = tpfc_pkg::COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   tpfc_pkg::outcome_type outcome;
   logic [COORD_BITS-1:0] screen_x;
   logic [COORD_BITS-1:0] screen_y;
   logic [RAW_BITS-1:0]   avg_x;
   logic [RAW_BITS-1:0]   avg_y;

   modport source (output valid, outcome, screen_x, screen_y, avg_x, avg_y,
                   input ready);
   modport sink   (input valid, outcome, screen_x, screen_y, avg_x, avg_y,
                   output ready);
endinterface

interface tpfc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tpfc_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [tpfc_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/tpfc_csr_regs.sv
module tpfc_csr_regs #(
   parameter int RAW_BITS   = tpfc_pkg::RAW_BITS_DEFAULT,
   parameter int COORD_BITS = tpfc_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   tpfc_csr_if.sink                            csr_chan,
   output logic [RAW_BITS-1:0]                 center_x,
   output logic [RAW_BITS-1:0]                 center_y,
   output logic signed [tpfc_pkg::GAIN_BITS-1:0] gain_x,
   output logic signed [tpfc_pkg::GAIN_BITS-1:0] gain_y,
   output logic [COORD_BITS-1:0]               screen_width,
   output logic [COORD_BITS-1:0]               screen_height,
   output logic [RAW_BITS-1:0]                 agree_limit
);
   import tpfc_pkg::*;

   logic [RAW_BITS-1:0]          center_x_ff, center_x_in;
   logic [RAW_BITS-1:0]          center_y_ff, center_y_in;
   logic signed [GAIN_BITS-1:0]  gain_x_ff, gain_x_in;
   logic signed [GAIN_BITS-1:0]  gain_y_ff, gain_y_in;
   logic [COORD_BITS-1:0]        width_ff, width_in;
   logic [COORD_BITS-1:0]        height_ff, height_in;
   logic [RAW_BITS-1:0]          agree_ff, agree_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      gain_x_in   = gain_x_ff;
      gain_y_in   = gain_y_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      agree_in    = agree_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_CENTER_X:    center_x_in = csr_chan.data[RAW_BITS-1:0];
            CSR_CENTER_Y:    center_y_in = csr_chan.data[RAW_BITS-1:0];
            CSR_GAIN_X:      gain_x_in   = signed'(csr_chan.data[GAIN_BITS-1:0]);
            CSR_GAIN_Y:      gain_y_in   = signed'(csr_chan.data[GAIN_BITS-1:0]);
            CSR_WIDTH:       width_in    = csr_chan.data[COORD_BITS-1:0];
            CSR_HEIGHT:      height_in   = csr_chan.data[COORD_BITS-1:0];
            CSR_AGREE_LIMIT: agree_in    = csr_chan.data[RAW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= RAW_BITS'(CENTER_RESET);
         center_y_ff <= RAW_BITS'(CENTER_RESET);
         gain_x_ff   <= GAIN_BITS'(GAIN_X_RESET);
         gain_y_ff   <= GAIN_BITS'(GAIN_Y_RESET);
         width_ff    <= COORD_BITS'(WIDTH_RESET);
         height_ff   <= COORD_BITS'(HEIGHT_RESET);
         agree_ff    <= RAW_BITS'(AGREE_RESET);
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
         gain_x_ff   <= gain_x_in;
         gain_y_ff   <= gain_y_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         agree_ff    <= agree_in;
      end
   end

   assign center_x      = center_x_ff;
   assign center_y      = center_y_ff;
   assign gain_x        = gain_x_ff;
   assign gain_y        = gain_y_ff;
   assign screen_width  = width_ff;
   assign screen_height = height_ff;
   assign agree_limit   = agree_ff;

endmodule

// File: rtl/tpfc_front.sv
module tpfc_front #(
   parameter int RAW_BITS = tpfc_pkg::RAW_BITS_DEFAULT,
   parameter int PROD_W   = RAW_BITS + 1 + tpfc_pkg::GAIN_BITS
) (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic                                  pen_down,
   input  logic [RAW_BITS-1:0]                   first_x,
   input  logic [RAW_BITS-1:0]                   first_y,
   input  logic [RAW_BITS-1:0]                   second_x,
   input  logic [RAW_BITS-1:0]                   second_y,
   input  logic [RAW_BITS-1:0]                   center_x,
   input  logic [RAW_BITS-1:0]                   center_y,
   input  logic signed [tpfc_pkg::GAIN_BITS-1:0] gain_x,
   input  logic signed [tpfc_pkg::GAIN_BITS-1:0] gain_y,
   input  logic [RAW_BITS-1:0]                   agree_limit,
   output tpfc_pkg::mid_flags_type               flags,
   output logic [RAW_BITS-1:0]                   avg_x,
   output logic [RAW_BITS-1:0]                   avg_y,
   output logic signed [PROD_W-1:0]              prod_x,
   output logic signed [PROD_W-1:0]              prod_y
);
   import tpfc_pkg::*;

   logic [RAW_BITS-1:0]        diff_x, diff_y;
   logic [RAW_BITS:0]          sum_x, sum_y;
   logic signed [RAW_BITS:0]   dev_x, dev_y;
   mid_flags_type              flags_ff, flags_in;
   logic [RAW_BITS-1:0]        avg_x_ff, avg_x_in, avg_y_ff, avg_y_in;
   logic signed [PROD_W-1:0]   prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;

   always_comb begin
      diff_x = (first_x >= second_x) ? first_x - second_x : second_x - first_x;
      diff_y = (first_y >= second_y) ? first_y - second_y : second_y - first_y;
      sum_x  = {1'b0, first_x} + {1'b0, second_x};
      sum_y  = {1'b0, first_y} + {1'b0, second_y};
      dev_x  = signed'({1'b0, sum_x[RAW_BITS:1]}) - signed'({1'b0, center_x});
      dev_y  = signed'({1'b0, sum_y[RAW_BITS:1]}) - signed'({1'b0, center_y});

      flags_in  = flags_ff;
      avg_x_in  = avg_x_ff;
      avg_y_in  = avg_y_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      if (enable) begin
         flags_in.pen_down = pen_down;
         flags_in.agree    = (diff_x < agree_limit) && (diff_y < agree_limit);
         avg_x_in          = sum_x[RAW_BITS:1];
         avg_y_in          = sum_y[RAW_BITS:1];
         prod_x_in         = PROD_W'(dev_x) * PROD_W'(gain_x);
         prod_y_in         = PROD_W'(dev_y) * PROD_W'(gain_y);
      end
   end

   always_ff @(posedge clock) begin
      flags_ff  <= flags_in;
      avg_x_ff  <= avg_x_in;
      avg_y_ff  <= avg_y_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
   end

   assign flags  = flags_ff;
   assign avg_x  = avg_x_ff;
   assign avg_y  = avg_y_ff;
   assign prod_x = prod_x_ff;
   assign prod_y = prod_y_ff;

endmodule

// File: rtl/tpfc_classify.sv
module tpfc_classify #(
   parameter int RAW_BITS   = tpfc_pkg::RAW_BITS_DEFAULT,
   parameter int COORD_BITS = tpfc_pkg::COORD_BITS_DEFAULT,
   parameter int PROD_W     = RAW_BITS + 1 + tpfc_pkg::GAIN_BITS
) (
   input  logic                        clock,
   input  logic                        enable,
   input  tpfc_pkg::mid_flags_type     flags,
   input  logic [RAW_BITS-1:0]         avg_x,
   input  logic [RAW_BITS-1:0]         avg_y,
   input  logic signed [PROD_W-1:0]    prod_x,
   input  logic signed [PROD_W-1:0]    prod_y,
   input  logic [COORD_BITS-1:0]       screen_width,
   input  logic [COORD_BITS-1:0]       screen_height,
   output tpfc_pkg::outcome_type       outcome,
   output logic [COORD_BITS-1:0]       screen_x,
   output logic [COORD_BITS-1:0]       screen_y,
   output logic [RAW_BITS-1:0]         avg_x_out,
   output logic [RAW_BITS-1:0]         avg_y_out
);
   import tpfc_pkg::*;

   localparam int T_W  = PROD_W - FRAC_BITS;
   localparam int LX_W = T_W + COORD_BITS + 2;

   // size - (trunc(prod / 2^16) + size / 2)
   function automatic logic signed [LX_W-1:0] map_axis(
      input logic signed [PROD_W-1:0] prod,
      input logic [COORD_BITS-1:0]    size
   );
      logic signed [T_W-1:0]  t;
      logic signed [LX_W-1:0] s;
      logic signed [LX_W-1:0] h;
      t = signed'(prod[PROD_W-1:FRAC_BITS]);
      if (prod[PROD_W-1] && (prod[FRAC_BITS-1:0] != '0))
         t = t + T_W'(1);
      s = LX_W'({1'b0, size});
      h = LX_W'({1'b0, size[COORD_BITS-1:1]});
      return s - (LX_W'(t) + h);
   endfunction

   logic signed [LX_W-1:0]  lx, ly, size_x, size_y;
   logic                    off_screen, corner;
   outcome_type             outcome_ff, outcome_in;
   logic [COORD_BITS-1:0]   screen_x_ff, screen_x_in, screen_y_ff, screen_y_in;
   logic [RAW_BITS-1:0]     avg_x_ff, avg_x_in, avg_y_ff, avg_y_in;

   always_comb begin
      lx         = map_axis(prod_x, screen_width);
      ly         = map_axis(prod_y, screen_height);
      size_x     = LX_W'({1'b0, screen_width});
      size_y     = LX_W'({1'b0, screen_height});
      off_screen = (lx < 0) || (ly < 0) || (lx >= size_x) || (ly >= size_y);
      corner     = (lx > size_x - LX_W'(CORNER_WIDTH)) && (ly < LX_W'(CORNER_HEIGHT));

      outcome_in  = outcome_ff;
      screen_x_in = screen_x_ff;
      screen_y_in = screen_y_ff;
      avg_x_in    = avg_x_ff;
      avg_y_in    = avg_y_ff;
      if (enable) begin
         screen_x_in = '0;
         screen_y_in = '0;
         avg_x_in    = '0;
         avg_y_in    = '0;
         priority if (!flags.pen_down) begin
            outcome_in = OUTCOME_PEN_UP;
         end else if (!flags.agree) begin
            outcome_in = OUTCOME_DISAGREE;
         end else begin
            avg_x_in = avg_x;
            avg_y_in = avg_y;
            if (off_screen) begin
               outcome_in = OUTCOME_OFF;
            end else begin
               screen_x_in = lx[COORD_BITS-1:0];
               screen_y_in = ly[COORD_BITS-1:0];
               outcome_in  = corner ? OUTCOME_CORNER : OUTCOME_DRAW;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff  <= outcome_in;
      screen_x_ff <= screen_x_in;
      screen_y_ff <= screen_y_in;
      avg_x_ff    <= avg_x_in;
      avg_y_ff    <= avg_y_in;
   end

   assign outcome   = outcome_ff;
   assign screen_x  = screen_x_ff;
   assign screen_y  = screen_y_ff;
   assign avg_x_out = avg_x_ff;
   assign avg_y_out = avg_y_ff;

endmodule

// File: rtl/touch_point_filter_calibrate_core.sv
// A word accepted into the input register moves on to the multiply stage and then to
// the classify stage, whose register drives rsp. Throughput: one word per cycle while
// rsp is ready; input register, multiply stage, classify stage.
// Each stage advances whenever the stage after it is empty or moving on.
// Reset empties the pipeline and loads the calibration registers with their defaults.
module touch_point_filter_calibrate_core #(
   parameter int RAW_BITS   = tpfc_pkg::RAW_BITS_DEFAULT,
   parameter int COORD_BITS = tpfc_pkg::COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tpfc_req_if.sink    req_chan,
   tpfc_rsp_if.source  rsp_chan,
   tpfc_csr_if.sink    csr_chan
);
   import tpfc_pkg::*;

   localparam int PROD_W = RAW_BITS + 1 + GAIN_BITS;

   logic [RAW_BITS-1:0]         center_x, center_y, agree_limit;
   logic signed [GAIN_BITS-1:0] gain_x, gain_y;
   logic [COORD_BITS-1:0]       screen_width, screen_height;

   logic                        in_valid_ff, in_valid_in;
   logic                        mid_valid_ff, mid_valid_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        adv_in, adv_mid, adv_out;

   logic                        pen_ff, pen_in;
   logic [RAW_BITS-1:0]         fx_ff, fx_in, fy_ff, fy_in, sx_ff, sx_in, sy_ff, sy_in;

   mid_flags_type               mid_flags;
   logic [RAW_BITS-1:0]         mid_avg_x, mid_avg_y;
   logic signed [PROD_W-1:0]    mid_prod_x, mid_prod_y;

   tpfc_csr_regs #(
      .RAW_BITS   (RAW_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_chan      (csr_chan),
      .center_x      (center_x),
      .center_y      (center_y),
      .gain_x        (gain_x),
      .gain_y        (gain_y),
      .screen_width  (screen_width),
      .screen_height (screen_height),
      .agree_limit   (agree_limit)
   );

   always_comb begin
      adv_out = !out_valid_ff || rsp_chan.ready;
      adv_mid = !mid_valid_ff || adv_out;
      adv_in  = !in_valid_ff || adv_mid;

      in_valid_in  = adv_in  ? req_chan.valid : in_valid_ff;
      mid_valid_in = adv_mid ? in_valid_ff    : mid_valid_ff;
      out_valid_in = adv_out ? mid_valid_ff   : out_valid_ff;

      pen_in = pen_ff;
      fx_in  = fx_ff;
      fy_in  = fy_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      if (adv_in) begin
         pen_in = req_chan.pen_down;
         fx_in  = req_chan.first_x;
         fy_in  = req_chan.first_y;
         sx_in  = req_chan.second_x;
         sy_in  = req_chan.second_y;
      end
   end

   assign req_chan.ready = adv_in;
   assign rsp_chan.valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pen_ff <= pen_in;
      fx_ff  <= fx_in;
      fy_ff  <= fy_in;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
   end

   tpfc_front #(
      .RAW_BITS (RAW_BITS),
      .PROD_W   (PROD_W)
   ) u_front (
      .clock       (clock),
      .enable      (adv_mid),
      .pen_down    (pen_ff),
      .first_x     (fx_ff),
      .first_y     (fy_ff),
      .second_x    (sx_ff),
      .second_y    (sy_ff),
      .center_x    (center_x),
      .center_y    (center_y),
      .gain_x      (gain_x),
      .gain_y      (gain_y),
      .agree_limit (agree_limit),
      .flags       (mid_flags),
      .avg_x       (mid_avg_x),
      .avg_y       (mid_avg_y),
      .prod_x      (mid_prod_x),
      .prod_y      (mid_prod_y)
   );

   tpfc_classify #(
      .RAW_BITS   (RAW_BITS),
      .COORD_BITS (COORD_BITS),
      .PROD_W     (PROD_W)
   ) u_classify (
      .clock         (clock),
      .enable        (adv_out),
      .flags         (mid_flags),
      .avg_x         (mid_avg_x),
      .avg_y         (mid_avg_y),
      .prod_x        (mid_prod_x),
      .prod_y        (mid_prod_y),
      .screen_width  (screen_width),
      .screen_height (screen_height),
      .outcome       (rsp_chan.outcome),
      .screen_x      (rsp_chan.screen_x),
      .screen_y      (rsp_chan.screen_y),
      .avg_x_out     (rsp_chan.avg_x),
      .avg_y_out     (rsp_chan.avg_y)
   );

   a_point_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.outcome == OUTCOME_DRAW ||
                         rsp_chan.outcome == OUTCOME_CORNER)
      |-> (rsp_chan.screen_x < screen_width) && (rsp_chan.screen_y < screen_height))
      else $error("mapped point outside screen");

   a_no_point_when_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.outcome == OUTCOME_OFF ||
                         rsp_chan.outcome == OUTCOME_DISAGREE ||
                         rsp_chan.outcome == OUTCOME_PEN_UP)
      |-> (rsp_chan.screen_x == '0) && (rsp_chan.screen_y == '0))
      else $error("stale point on rejected word");

   a_no_avg_when_filtered: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.outcome == OUTCOME_DISAGREE ||
                         rsp_chan.outcome == OUTCOME_PEN_UP)
      |-> (rsp_chan.avg_x == '0) && (rsp_chan.avg_y == '0))
      else $error("average on filtered word");

   a_no_invented_word: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !mid_valid_ff |=> !rsp_chan.valid)
      else $error("output word without a source");

endmodule
